// ===== rtl/mpid_pkg.sv =====
// Shared types, constants and register indexes for the multichannel PID controller.
`default_nettype none

package mpid_pkg;

    localparam int MPID_CHANNELS = 4;

    localparam int CH_W    = 2;
    localparam int VAL_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int SUM_W   = 32;
    localparam int DRV_W   = 32;
    localparam int REG_W   = 64;
    localparam int IDX_W   = 3;

    localparam int P_W     = GAIN_W + ERR_W;
    localparam int I_W     = GAIN_W + SUM_W;
    localparam int D_W     = GAIN_W + DIFF_W;
    localparam int ACC_W   = 50;
    localparam int FRAC_W  = 8;
    localparam int Q_W     = ACC_W - FRAC_W;

    localparam logic [IDX_W-1:0] REG_PROP_GAINS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAINS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DERIV_GAINS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTEG_ENABLE = 3'd3;
    localparam logic [IDX_W-1:0] REG_DERIV_ENABLE = 3'd4;

    typedef struct packed {
        logic [REG_W-1:0] prop_gains;
        logic [REG_W-1:0] integ_gains;
        logic [REG_W-1:0] deriv_gains;
        logic             integ_enable;
        logic             deriv_enable;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [ERR_W-1:0]  err;
        logic [SUM_W-1:0]  sum;
        logic [DIFF_W-1:0] diff;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_err_data;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic [P_W-1:0]  p_term;
        logic [I_W-1:0]  i_term;
        logic [D_W-1:0]  d_term;
    } t_prod_data;

endpackage

`default_nettype wire

// ===== rtl/mpid_cfg.sv =====
// Configuration register file: gains and term enables.
`default_nettype none

module mpid_cfg
    import mpid_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PROP_GAINS:   r_cfg.prop_gains   <= i_cfg_data;
                REG_INTEG_GAINS:  r_cfg.integ_gains  <= i_cfg_data;
                REG_DERIV_GAINS:  r_cfg.deriv_gains  <= i_cfg_data;
                REG_INTEG_ENABLE: r_cfg.integ_enable <= i_cfg_data[0];
                REG_DERIV_ENABLE: r_cfg.deriv_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mpid_err_stage.sv =====
// Error stage: per-channel state, error, saturating sum, difference and gain select.
`default_nettype none

module mpid_err_stage
    import mpid_pkg::*;
#(
    parameter int CHANNELS = MPID_CHANNELS
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [CH_W-1:0]  i_ch,
    input  wire logic [VAL_W-1:0] i_meas,
    input  wire logic [VAL_W-1:0] i_des,
    input  wire t_cfg             i_cfg,
    output logic                  o_valid,
    output t_err_data             o_data,
    input  wire logic             i_ready
);

    localparam int SI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(CHANNELS);

    logic [SUM_W-1:0] r_sum  [CHANNELS];
    logic [ERR_W-1:0] r_last [CHANNELS];
    logic [CHANNELS-1:0] r_has;
    logic             r_valid;
    t_err_data        r_data;

    logic              ch_ok;
    logic [SI_W-1:0]   idx;
    logic [ERR_W-1:0]  err;
    logic [SUM_W-1:0]  cur_sum;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  n_sum;
    logic [ERR_W-1:0]  cur_last;
    logic              cur_has;
    logic [DIFF_W-1:0] diff;
    logic [5:0]        goff;
    logic              load;
    t_err_data         n_data;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        ch_ok    = {1'b0, i_ch} < CH_LIM;
        idx      = i_ch[SI_W-1:0];
        err      = {i_des[VAL_W-1], i_des} - {i_meas[VAL_W-1], i_meas};
        cur_sum  = ch_ok ? r_sum[idx] : '0;
        cur_last = ch_ok ? r_last[idx] : '0;
        cur_has  = ch_ok && r_has[idx];
        sum_ext  = {cur_sum[SUM_W-1], cur_sum} + {{(SUM_W + 1 - ERR_W){err[ERR_W-1]}}, err};
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            n_sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            n_sum = sum_ext[SUM_W-1:0];
        end
        diff = {err[ERR_W-1], err} - {cur_last[ERR_W-1], cur_last};
        goff = {i_ch, 4'b0000};

        n_data.ch   = i_ch;
        n_data.err  = err;
        n_data.sum  = n_sum;
        n_data.diff = diff;
        n_data.kp   = ch_ok ? i_cfg.prop_gains[goff +: GAIN_W] : '0;
        n_data.ki   = (ch_ok && i_cfg.integ_enable) ? i_cfg.integ_gains[goff +: GAIN_W] : '0;
        n_data.kd   = (cur_has && i_cfg.deriv_enable) ? i_cfg.deriv_gains[goff +: GAIN_W] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_has   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c]  <= '0;
                r_last[c] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load && ch_ok) begin
                if (i_cfg.integ_enable) begin
                    r_sum[idx] <= n_sum;
                end
                r_last[idx] <= err;
                r_has[idx]  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mpid_mult_stage.sv =====
// Product stage: the three gain multiplies, registered.
`default_nettype none

module mpid_mult_stage
    import mpid_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_err_data i_data,
    output logic           o_valid,
    output t_prod_data     o_data,
    input  wire logic      i_ready
);

    logic        r_valid;
    t_prod_data  r_data;
    logic        load;

    logic signed [P_W-1:0] p_term;
    logic signed [I_W-1:0] i_term;
    logic signed [D_W-1:0] d_term;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign p_term = $signed(i_data.kp) * $signed(i_data.err);
    assign i_term = $signed(i_data.ki) * $signed(i_data.sum);
    assign d_term = $signed(i_data.kd) * $signed(i_data.diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.ch     <= i_data.ch;
            r_data.p_term <= p_term;
            r_data.i_term <= i_term;
            r_data.d_term <= d_term;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mpid_out_stage.sv =====
// Output stage: term sum, Q8.8 floor shift, 32-bit saturation and result register.
`default_nettype none

module mpid_out_stage
    import mpid_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_prod_data       i_data,
    output logic                  o_valid,
    output logic [CH_W-1:0]       o_ch,
    output logic [DRV_W-1:0]      o_drive,
    output logic                  o_sat,
    input  wire logic             i_ready
);

    logic             r_valid;
    logic [CH_W-1:0]  r_ch;
    logic [DRV_W-1:0] r_drive;
    logic             r_sat;
    logic             load;

    logic signed [ACC_W-1:0] acc;
    logic [Q_W-1:0]          q;
    logic                    sat;
    logic [DRV_W-1:0]        n_drive;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_ch    = r_ch;
    assign o_drive = r_drive;
    assign o_sat   = r_sat;

    always_comb begin
        acc = $signed(i_data.p_term) + $signed(i_data.i_term) + $signed(i_data.d_term);
        q   = acc[ACC_W-1:FRAC_W];
        sat = !((&q[Q_W-1:DRV_W-1]) || !(|q[Q_W-1:DRV_W-1]));
        if (sat) begin
            n_drive = q[Q_W-1] ? {1'b1, {(DRV_W - 1){1'b0}}} : {1'b0, {(DRV_W - 1){1'b1}}};
        end else begin
            n_drive = q[DRV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ch    <= i_data.ch;
            r_drive <= n_drive;
            r_sat   <= sat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/multichannel_pid_controller_core.sv =====
// Path to the master side: input register, error stage, product stage, output stage.
// Throughput: one sample per cycle while i_m_tready is high, same channel or not; channel
// state is read and written in the error stage; each sample sees its predecessor's update.
// Every stage holds its result while the next one stalls and refills as soon as it drains.
// Reset (synchronous, active low) clears all gains, enables, channel state and valid flags.
`default_nettype none

module multichannel_pid_controller_core
    import mpid_pkg::*;
#(
    parameter int CHANNELS = MPID_CHANNELS
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [31:0]      i_s_tdata,   // measured[15:0], desired[31:16]
    input  wire logic [CH_W-1:0]  i_s_tuser,   // channel[1:0]
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [DRV_W-1:0]      o_m_tdata,   // drive[31:0]
    output logic [CH_W:0]         o_m_tuser,   // out_channel[1:0], saturated[2]
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0] i_cfg_data
);

    t_cfg cfg;

    logic             r_in_valid;
    logic [CH_W-1:0]  r_in_ch;
    logic [VAL_W-1:0] r_in_meas;
    logic [VAL_W-1:0] r_in_des;

    logic       err_ready;
    logic       err_valid;
    t_err_data  err_data;
    logic       mult_ready;
    logic       mult_valid;
    t_prod_data mult_data;
    logic       out_ready;
    logic [CH_W-1:0]  out_ch;
    logic [DRV_W-1:0] out_drive;
    logic             out_sat;

    assign o_s_tready = !r_in_valid || err_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ch   <= i_s_tuser;
            r_in_meas <= i_s_tdata[VAL_W-1:0];
            r_in_des  <= i_s_tdata[2*VAL_W-1:VAL_W];
        end
    end

    mpid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mpid_err_stage #(
        .CHANNELS (CHANNELS)
    ) u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (err_ready),
        .i_ch    (r_in_ch),
        .i_meas  (r_in_meas),
        .i_des   (r_in_des),
        .i_cfg   (cfg),
        .o_valid (err_valid),
        .o_data  (err_data),
        .i_ready (mult_ready)
    );

    mpid_mult_stage u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (err_valid),
        .o_ready (mult_ready),
        .i_data  (err_data),
        .o_valid (mult_valid),
        .o_data  (mult_data),
        .i_ready (out_ready)
    );

    mpid_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mult_valid),
        .o_ready (out_ready),
        .i_data  (mult_data),
        .o_valid (o_m_tvalid),
        .o_ch    (out_ch),
        .o_drive (out_drive),
        .o_sat   (out_sat),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = out_drive;
    assign o_m_tuser = {out_sat, out_ch};

    localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(CHANNELS);

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && out_sat |->
            (out_drive == {1'b1, {(DRV_W - 1){1'b0}}}) ||
            (out_drive == {1'b0, {(DRV_W - 1){1'b1}}}))
        else $error("saturated result not at a range limit");

    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ({1'b0, out_ch} >= CH_LIM) |-> (out_drive == '0) && !out_sat)
        else $error("result for unused channel is not zero");

    a_empty_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_m_tvalid && !err_valid && !mult_valid)
        else $error("pipeline holds data after reset");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && err_valid && mult_valid && o_m_tvalid && !i_m_tready)
        else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire
